@@ rtl/core/tcr8_pkg.sv @@
// Shared types, register indexes and the sRGB decode table for the texel byte converter.
`timescale 1ns / 1ps
`default_nettype none

package tcr8_pkg;

    // Source format codes held in the source format register.
    typedef enum logic [2:0] {
        FMT_FLOAT32 = 3'd0,
        FMT_UNORM32 = 3'd1,
        FMT_UNORM16 = 3'd2,
        FMT_UNORM8  = 3'd3,
        FMT_SRGB8   = 3'd4
    } tcr8_format_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;

    // Register values after reset.
    localparam logic [2:0] SOURCE_FORMAT_RESET = 3'd3;
    localparam logic [2:0] CHANNEL_COUNT_RESET = 3'd4;

    // Channel count that asks for an opaque alpha byte after every texel.
    localparam logic [2:0] RGB_CHANNEL_COUNT = 3'd3;
    // Byte position that an inserted alpha byte occupies.
    localparam logic [1:0] ALPHA_POSITION = 2'd3;
    localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

    typedef logic [255:0][7:0] tcr8_srgb_lut_t;

    // Exact floor(255 * L(i/255)) for the standard sRGB decode. Above the linear
    // segment, y >= k holds exactly when 255^5 * (40i+561)^12 >= k^5 * 10761^12,
    // so the largest such k is found bit by bit with wide integers.
    function automatic logic [7:0] srgb_entry(input int unsigned idx);
        logic [223:0] base;
        logic [223:0] lhs;
        logic [223:0] rhs;
        logic [7:0]   k;
        logic [7:0]   cand;
        int           n;
        int           b;
        base = 224'd1;
        for (n = 0; n < 12; n++) begin
            base = base * 224'd10761;
        end
        lhs = 224'd1;
        for (n = 0; n < 12; n++) begin
            lhs = lhs * 224'(40 * idx + 561);
        end
        for (n = 0; n < 5; n++) begin
            lhs = lhs * 224'd255;
        end
        k = 8'd0;
        for (b = 7; b >= 0; b--) begin
            cand = k | (8'd1 << b);
            rhs = base;
            for (n = 0; n < 5; n++) begin
                rhs = rhs * 224'(cand);
            end
            if (lhs >= rhs) begin
                k = cand;
            end
        end
        if (idx < 11) begin
            k = 8'd0;
        end
        return k;
    endfunction

    function automatic tcr8_srgb_lut_t build_srgb_lut();
        tcr8_srgb_lut_t lut;
        int             i;
        for (i = 0; i < 256; i++) begin
            lut[i] = srgb_entry(i);
        end
        return lut;
    endfunction

    localparam tcr8_srgb_lut_t SRGB_LUT = build_srgb_lut();

endpackage

`default_nettype wire

@@ rtl/core/tcr8_float_to_byte.sv @@
// Single-precision float to 8-bit unorm conversion with truncation and clamping.
`timescale 1ns / 1ps
`default_nettype none

module tcr8_float_to_byte
    import tcr8_pkg::*;
(
    input  wire logic [31:0] float_bits,
    output logic      [7:0]  byte_value
);

    logic        sign_bit;
    logic [7:0]  exponent;
    logic [22:0] fraction;
    logic [23:0] mantissa;
    logic [31:0] product;
    logic        product_high;
    logic [23:0] kept;
    logic        guard_bit;
    logic        sticky_bit;
    logic [24:0] rounded;
    logic [8:0]  shift_limit;
    logic [8:0]  shift_count;
    logic [24:0] shifted;

    assign sign_bit = float_bits[31];
    assign exponent = float_bits[30:23];
    assign fraction = float_bits[22:0];
    assign mantissa = {(exponent != 8'd0), fraction};

    // mantissa * 255, then rounded to 24 significant bits, ties to even.
    assign product      = {mantissa, 8'd0} - {8'd0, mantissa};
    assign product_high = product[31];
    assign kept         = product_high ? product[31:8] : product[30:7];
    assign guard_bit    = product_high ? product[7] : product[6];
    assign sticky_bit   = product_high ? (|product[6:0]) : (|product[5:0]);
    assign rounded      = {1'b0, kept} + 25'(guard_bit & (sticky_bit | kept[0]));

    // The rounded value is at least 2^23, so a non-negative scale always saturates.
    assign shift_limit = product_high ? 9'd142 : 9'd143;
    assign shift_count = shift_limit - {1'b0, exponent};
    assign shifted     = rounded >> shift_count[4:0];

    always_comb begin
        if (exponent == 8'hFF) begin
            byte_value = ((fraction != 23'd0) || sign_bit) ? 8'd0 : 8'hFF;
        end else if (sign_bit) begin
            byte_value = 8'd0;
        end else if ({1'b0, exponent} >= shift_limit) begin
            byte_value = 8'hFF;
        end else if (shift_count >= 9'd25) begin
            byte_value = 8'd0;
        end else if (|shifted[24:8]) begin
            byte_value = 8'hFF;
        end else begin
            byte_value = shifted[7:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tcr8_convert.sv @@
// Format-dependent conversion of one raw texel component to an 8-bit unorm byte.
`timescale 1ns / 1ps
`default_nettype none

module tcr8_convert
    import tcr8_pkg::*;
(
    input  wire logic [2:0]  source_format,
    input  wire logic [31:0] component,
    output logic      [7:0]  byte_value
);

    logic [7:0]  float_byte;
    logic [39:0] scaled32;
    logic [32:0] fold32;
    logic [7:0]  unorm32_byte;
    logic [23:0] scaled16;
    logic [16:0] fold16;
    logic [7:0]  unorm16_byte;

    tcr8_float_to_byte u_float (
        .float_bits (component),
        .byte_value (float_byte)
    );

    // floor(c*255 / (2^n - 1)): with c*255 = q*2^n + r, the quotient is q,
    // plus one when q + r reaches 2^n - 1.
    assign scaled32     = {component, 8'd0} - {8'd0, component};
    assign fold32       = {1'b0, scaled32[31:0]} + {25'd0, scaled32[39:32]};
    assign unorm32_byte = scaled32[39:32] + 8'(fold32 >= 33'h0_FFFF_FFFF);

    assign scaled16     = {component[15:0], 8'd0} - {8'd0, component[15:0]};
    assign fold16       = {1'b0, scaled16[15:0]} + {9'd0, scaled16[23:16]};
    assign unorm16_byte = scaled16[23:16] + 8'(fold16 >= 17'h0_FFFF);

    always_comb begin
        case (source_format)
            FMT_FLOAT32: byte_value = float_byte;
            FMT_UNORM32: byte_value = unorm32_byte;
            FMT_UNORM16: byte_value = unorm16_byte;
            FMT_UNORM8:  byte_value = component[7:0];
            FMT_SRGB8:   byte_value = SRGB_LUT[component[7:0]];
            default:     byte_value = 8'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/texel_component_to_rgba8.sv @@
// Top level of the texel component to RGBA8 unorm byte converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts a stream of raw texel components, one per transfer, into 8-bit unorm
// bytes. The source format register selects float32, unorm32, unorm16, unorm8
// or sRGB8 decoding; with a channel count of three, an opaque alpha byte of 255
// follows every third component. That alpha byte carries last_of_run high, and the
// component byte just before it carries last_of_run low, so the two bytes caused by
// one input transfer can be told apart. Each accepted component passes through an
// input register, the combinational conversion logic and an output register, from
// which the converted byte is offered. The block sustains one component per cycle
// while the receiver is ready; an inserted alpha byte occupies the output register
// and holds off the next component meanwhile. Configuration writes are taken in
// every cycle and should only be made while no transfer is in flight. The sRGB
// decode table is a constant built at elaboration.
module texel_component_to_rgba8
    import tcr8_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [2:0]  cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_component,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_out_byte,
    output logic             m_last_of_run
);

    logic [2:0]  source_format_reg;
    logic [2:0]  channel_count_reg;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] in_component_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic        out_last_reg;
    logic        out_last_next;

    logic        alpha_pending_reg;
    logic        alpha_pending_next;
    logic [1:0]  byte_position_reg;
    logic [1:0]  byte_position_next;

    logic [7:0]  converted_byte;
    logic        out_free;
    logic        component_load;
    logic        alpha_load;
    logic        in_take;
    logic [1:0]  position_step;
    logic        insert_alpha;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_format_reg <= SOURCE_FORMAT_RESET;
            channel_count_reg <= CHANNEL_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_SOURCE_FORMAT) begin
                source_format_reg <= cfg_data;
            end else if (cfg_index == REG_CHANNEL_COUNT) begin
                channel_count_reg <= cfg_data;
            end
        end
    end

    tcr8_convert u_convert (
        .source_format (source_format_reg),
        .component     (in_component_reg),
        .byte_value    (converted_byte)
    );

    // The output register frees up when it is empty or its byte leaves this cycle.
    // A pending alpha byte goes out before the next converted component.
    assign out_free       = !out_valid_reg || m_ready;
    assign alpha_load     = alpha_pending_reg && out_free;
    assign component_load = in_valid_reg && !alpha_pending_reg && out_free;
    assign in_take        = s_valid && s_ready;
    assign s_ready        = !in_valid_reg || component_load;

    // The texel position advances for every component; with three channels the
    // step onto the alpha slot inserts the alpha byte and wraps to zero.
    assign position_step = byte_position_reg + 2'd1;
    assign insert_alpha  = (channel_count_reg == RGB_CHANNEL_COUNT)
                           && (position_step == ALPHA_POSITION);

    always_comb begin
        in_valid_next      = in_valid_reg;
        out_valid_next     = out_valid_reg;
        out_byte_next      = out_byte_reg;
        out_last_next      = out_last_reg;
        alpha_pending_next = alpha_pending_reg;
        byte_position_next = byte_position_reg;

        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (component_load) begin
            in_valid_next = 1'b0;
        end

        if (alpha_load) begin
            out_valid_next     = 1'b1;
            out_byte_next      = OPAQUE_ALPHA;
            out_last_next      = 1'b1;
            alpha_pending_next = 1'b0;
        end else if (component_load) begin
            out_valid_next     = 1'b1;
            out_byte_next      = converted_byte;
            out_last_next      = !insert_alpha;
            alpha_pending_next = insert_alpha;
            byte_position_next = insert_alpha ? 2'd0 : position_step;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            alpha_pending_reg <= 1'b0;
            byte_position_reg <= 2'd0;
        end else begin
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            alpha_pending_reg <= alpha_pending_next;
            byte_position_reg <= byte_position_next;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_component_reg <= s_component;
        end
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_last_of_run = out_last_reg;

    // A pending alpha byte always sits behind a converted byte still in the
    // output register.
    a_pending_has_output: assert property (
        @(posedge aclk) disable iff (!aresetn)
        alpha_pending_reg |-> out_valid_reg
    ) else $error("alpha byte pending with an empty output register");

    // A byte without last_of_run is always followed by an alpha byte.
    a_not_last_means_pending: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_last_reg) |-> alpha_pending_reg
    ) else $error("non-final byte in the output register without a pending alpha");

    // Right after a non-final byte transfers, the opaque alpha byte is offered.
    a_alpha_follows: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run)
            |=> (m_valid && m_last_of_run && (m_out_byte == OPAQUE_ALPHA))
    ) else $error("inserted alpha byte did not follow its component");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the texel component to RGBA8 unorm byte converter.
`timescale 1ns / 1ps

// The testbench drives raw texel components into the converter and collects the bytes
// that it returns. A scoreboard class holds its own copy of the two configuration
// registers, the byte position within the current texel and the sRGB decode table. From
// these it works out the one or two bytes that each accepted component must produce.
// Every result transfer is checked in order against the oldest byte still pending.
//
// The run starts with a short directed part. That part covers the extremes of the
// component field and each source format. It also covers the float corner cases: signed
// zeros, infinities, NaN, negative values, overflow and denormals. It also writes the
// last reserved format code and several channel counts. Then follow twelve random phases.
// Each phase uses its own register setting and one of four mixes of sender gaps and
// receiver stalls. Registers are only written once all pending bytes have come back.
module testbench;
    import tcr8_pkg::*;

    // Register indexes that the block does not decode; writes to them must be ignored.
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;
    // Format codes beyond the defined set; they must give a zero byte.
    localparam logic [2:0] FMT_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] FMT_RESERVED_LAST  = 3'd7;

    localparam int PHASE_COUNT      = 12;
    localparam int PHASE_COMPONENTS = 160;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 8;

    // One output byte as it is expected on the result channel.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } rgba_byte_t;

    // Predicts the byte stream from accepted components and checks the bytes that come back.
    class rgba8_scoreboard;
        logic [2:0]  source_format;
        logic [2:0]  channel_count;
        logic [1:0]  byte_position;
        logic [7:0]  decode_lut [256];
        rgba_byte_t  expected_bytes [$];
        int unsigned mismatches;
        int unsigned components_seen;
        int unsigned bytes_checked;
        int unsigned alpha_bytes;

        function new();
            source_format   = SOURCE_FORMAT_RESET;
            channel_count   = CHANNEL_COUNT_RESET;
            byte_position   = 2'd0;
            mismatches      = 0;
            components_seen = 0;
            bytes_checked   = 0;
            alpha_bytes     = 0;
            build_decode_lut();
        endfunction

        // Entry i is floor(255 * L(i/255)), found exactly. Above the linear segment the
        // test y >= k is equivalent to 255^5 * (40i+561)^12 >= k^5 * 10761^12, so the level
        // climbs monotonically as i grows and one linear search covers the whole table.
        function void build_decode_lut();
            logic [223:0] scale;
            logic [223:0] lhs;
            logic [223:0] rhs;
            int unsigned  level;
            int           i;
            int           n;
            scale = 224'd1;
            for (n = 0; n < 12; n++) begin
                scale = scale * 224'd10761;
            end
            level = 0;
            for (i = 0; i < 256; i++) begin
                if (i < 11) begin
                    decode_lut[i] = 8'd0;
                end else begin
                    lhs = 224'd1;
                    for (n = 0; n < 12; n++) begin
                        lhs = lhs * 224'(40 * i + 561);
                    end
                    for (n = 0; n < 5; n++) begin
                        lhs = lhs * 224'd255;
                    end
                    while (level < 255) begin
                        rhs = scale;
                        for (n = 0; n < 5; n++) begin
                            rhs = rhs * 224'(level + 1);
                        end
                        if (lhs >= rhs) begin
                            level++;
                        end else begin
                            break;
                        end
                    end
                    decode_lut[i] = 8'(level);
                end
            end
        endfunction

        // The product c*255 is rounded like an IEEE single (24 bits, ties to even),
        // then truncated toward zero and clamped to a byte.
        function logic [7:0] float_to_unorm8(logic [31:0] bits);
            logic [63:0] prod;
            logic [63:0] rem;
            logic [63:0] half;
            logic [63:0] mag;
            int          exp_val;
            int          len;
            int          sh;
            int          i;
            if (bits[30:23] == 8'hFF) begin
                return (bits[22:0] != 23'd0 || bits[31]) ? 8'd0 : 8'd255;
            end
            if (bits[31] || bits[30:0] == 31'd0) begin
                return 8'd0;
            end
            prod    = 64'({bits[30:23] != 8'd0, bits[22:0]}) * 64'd255;
            exp_val = (bits[30:23] != 8'd0 ? int'(bits[30:23]) : 1) - 150;
            len = 0;
            for (i = 0; i < 64; i++) begin
                if (prod[i]) begin
                    len = i + 1;
                end
            end
            if (len > 24) begin
                sh   = len - 24;
                rem  = prod & ((64'd1 << sh) - 64'd1);
                half = 64'd1 << (sh - 1);
                prod = prod >> sh;
                if (rem > half || (rem == half && prod[0])) begin
                    prod = prod + 64'd1;
                end
                exp_val = exp_val + sh;
            end
            if (exp_val >= 0) begin
                if (exp_val > 8) begin
                    return 8'd255;
                end
                mag = prod << exp_val;
            end else begin
                if (-exp_val >= 64) begin
                    return 8'd0;
                end
                mag = prod >> (-exp_val);
            end
            return (mag > 64'd255) ? 8'd255 : mag[7:0];
        endfunction

        function logic [7:0] to_unorm8(logic [31:0] c);
            logic [63:0] wide;
            case (source_format)
                FMT_FLOAT32: return float_to_unorm8(c);
                FMT_UNORM32: begin
                    wide = (64'(c) * 64'd255) / 64'hFFFF_FFFF;
                    return wide[7:0];
                end
                FMT_UNORM16: begin
                    wide = (64'(c[15:0]) * 64'd255) / 64'd65535;
                    return wide[7:0];
                end
                FMT_UNORM8:  return c[7:0];
                FMT_SRGB8:   return decode_lut[c[7:0]];
                default:     return 8'd0;
            endcase
        endfunction

        function void apply_register_write(logic [1:0] index, logic [2:0] value);
            case (index)
                REG_SOURCE_FORMAT: source_format = value;
                REG_CHANNEL_COUNT: channel_count = value;
                default: ;
            endcase
        endfunction

        // The position advances for every component; with three channels the fourth slot
        // is filled by an opaque alpha byte, which then carries last_of_run alone.
        function void note_component(logic [31:0] c);
            rgba_byte_t item;
            logic       with_alpha;
            components_seen++;
            byte_position    = byte_position + 2'd1;
            with_alpha       = (channel_count == RGB_CHANNEL_COUNT) &&
                               (byte_position == ALPHA_POSITION);
            item.out_byte    = to_unorm8(c);
            item.last_of_run = !with_alpha;
            expected_bytes.push_back(item);
            if (with_alpha) begin
                byte_position    = 2'd0;
                item.out_byte    = OPAQUE_ALPHA;
                item.last_of_run = 1'b1;
                expected_bytes.push_back(item);
                alpha_bytes++;
            end
        endfunction

        function void check_byte(logic [7:0] got_byte, logic got_last);
            rgba_byte_t want;
            if (expected_bytes.size() == 0) begin
                $error("unexpected result transfer: out_byte %0d, last_of_run %0d",
                       got_byte, got_last);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (got_byte !== want.out_byte) begin
                $error("out_byte: expected %0d, got %0d", want.out_byte, got_byte);
                mismatches++;
            end
            if (got_last !== want.last_of_run) begin
                $error("last_of_run: expected %0d, got %0d", want.last_of_run, got_last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_bytes.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [1:0]  cfg_index   = REG_SOURCE_FORMAT;
    logic [2:0]  cfg_data    = 3'd0;
    logic        s_valid     = 1'b0;
    logic [31:0] s_component = 32'd0;
    logic        m_ready     = 1'b0;
    wire         cfg_ready;
    wire         s_ready;
    wire         m_valid;
    wire  [7:0]  m_out_byte;
    wire         m_last_of_run;

    // Idle mix of the current phase, in percent of cycles, and the remaining length of a
    // deliberate receiver hold-off.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_left      = 0;

    rgba8_scoreboard sb;

    texel_component_to_rgba8 u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_component   (s_component),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // A hard limit on run time. A correct run needs well under a tenth of it, even with
    // every phase stalled and every component followed by alpha.
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // The receiver decides its ready for each cycle on its own. A hold-off request
    // overrides the random choice and is counted down here, one cycle at a time.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // All three channels are observed at the clock edge. The values read here are the
    // ones from before the edge, since every driver on both sides uses nonblocking
    // assignments.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.apply_register_write(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                sb.note_component(s_component);
            end
            if (m_valid && m_ready) begin
                sb.check_byte(m_out_byte, m_last_of_run);
            end
        end
    end

    // Offers one component, after a random gap, and returns at the edge of its transfer.
    // Valid is left high so that back-to-back components need no extra edge.
    task automatic send_component(input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_component <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops the input and waits until every pending byte has been received. The wait
    // begins only after an edge, so that a component taken at the current edge is already
    // counted. It then waits longer still, so that nothing is still in flight when a
    // register is written.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [2:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [2:0] fmt, input logic [2:0] channels);
        wait_for_drain();
        write_register(REG_SOURCE_FORMAT, fmt);
        write_register(REG_CHANNEL_COUNT, channels);
    endtask

    // Random components are shaped by format. Part of them is raw bits, so that every bit
    // toggles. For unorm32 and unorm16 the rest lands near multiples of 1/255, where the
    // output byte changes; for floats it covers 1/256 to beyond 256, infinities, NaN and denormals.
    function automatic logic [31:0] random_component(input logic [2:0] fmt);
        logic [31:0] raw;
        logic [31:0] step;
        logic [31:0] nudge;
        raw   = $urandom;
        step  = $urandom_range(255);
        nudge = $urandom_range(2);
        case (fmt)
            FMT_FLOAT32: begin
                case ($urandom_range(4))
                    0: return raw;
                    1: return {1'b0, 8'($urandom_range(119, 126)), raw[22:0]};
                    2: return {1'b0, 8'($urandom_range(127, 135)), raw[22:0]};
                    3: return {raw[31], 8'hFF, $urandom_range(1) ? raw[22:0] : 23'd0};
                    default: return {raw[31], 8'h00, raw[22:0] >> $urandom_range(22)};
                endcase
            end
            FMT_UNORM32: begin
                if ($urandom_range(1)) begin
                    return raw;
                end
                return step * 32'h0101_0101 + nudge - 32'd1;
            end
            FMT_UNORM16: begin
                if ($urandom_range(1)) begin
                    return raw;
                end
                return {raw[31:16], 16'(step * 32'd257 + nudge - 32'd1)};
            end
            default: return raw;
        endcase
    endfunction

    initial begin
        int          phase;
        int          n;
        logic [2:0]  fmt;
        logic [2:0]  channels;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: unorm8 pass-through, four channels. Only the low byte counts.
        send_component(32'hFFFF_FFFF);
        send_component(32'h0000_0000);
        send_component(32'hABCD_EF5A);

        // Float corner cases with alpha insertion. The test covers signed zeros,
        // infinities, NaN, one, one half, overflow to 256, a negative value and the
        // smallest denormal.
        configure(FMT_FLOAT32, RGB_CHANNEL_COUNT);
        send_component(32'h0000_0000);
        send_component(32'h8000_0000);
        send_component(32'h7F80_0000);
        send_component(32'hFF80_0000);
        send_component(32'h7FC0_0000);
        send_component(32'h3F80_0000);
        send_component(32'h3F00_0000);
        send_component(32'h4380_0000);
        send_component(32'hBF80_0000);
        send_component(32'h0000_0001);

        // Full scale and the values just below and at the first step, 1/255.
        configure(FMT_UNORM32, 3'd4);
        send_component(32'hFFFF_FFFF);
        send_component(32'h0101_0100);
        send_component(32'h0101_0101);

        // The high half must be ignored.
        configure(FMT_UNORM16, RGB_CHANNEL_COUNT);
        send_component(32'hFFFF_0000);
        send_component(32'h0000_FFFF);
        send_component(32'h0000_0101);

        // Last entry of the linear segment that still gives zero, the first entry above
        // it, and full scale.
        configure(FMT_SRGB8, 3'd7);
        send_component(32'h0000_000A);
        send_component(32'h0000_000B);
        send_component(32'hFFFF_FFFF);

        configure(FMT_RESERVED_LAST, 3'd0);
        send_component(32'hFFFF_FFFF);

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            // Writes to undecoded indexes must leave both registers as they are.
            if (phase == 3) begin
                wait_for_drain();
                write_register(REG_SPARE_A, 3'($urandom));
                write_register(REG_SPARE_B, 3'($urandom));
            end
            case (phase % 6)
                0:       fmt = FMT_FLOAT32;
                1:       fmt = FMT_UNORM32;
                2:       fmt = FMT_UNORM16;
                3:       fmt = FMT_UNORM8;
                4:       fmt = FMT_SRGB8;
                default: fmt = 3'($urandom_range(FMT_RESERVED_FIRST, FMT_RESERVED_LAST));
            endcase
            // Three channels dominate, since that is where alpha insertion is exercised.
            // The other phases walk through every remaining count.
            case (phase)
                1:       channels = 3'd4;
                3:       channels = 3'd1;
                5:       channels = 3'd2;
                6:       channels = 3'd0;
                8:       channels = 3'd7;
                10:      channels = 3'd5;
                11:      channels = 3'd6;
                default: channels = RGB_CHANNEL_COUNT;
            endcase
            // The register setting is applied before the phase's idle mix.
            // The byte position carries over, so a phase may start partway into a texel.
            configure(fmt, channels);
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 75;
                end
                default: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            for (n = 0; n < PHASE_COMPONENTS; n++) begin
                // The receiver goes quiet for a long stretch while components keep coming.
                // This fills the pipeline and holds back the input.
                if (phase == 0 && n == 40) begin
                    hold_left = LONG_HOLD_CYCLES;
                end
                // The sender pauses until every pending byte has been delivered.
                if (phase == 5 && n == 80) begin
                    wait_for_drain();
                end
                send_component(random_component(fmt));
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d components and %0d bytes, %0d of them inserted alpha,",
                 sb.components_seen, sb.bytes_checked, sb.alpha_bytes);
        $display("over every source format, channel counts 0 to 7 and four idle mixes.");
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
